// ===== rtl/core/jetc_pkg.sv =====
// Package for the Julia escape-time counter: payload structs, controller/datapath
// command and status structs, and fixed widths.
// No dependencies.
`default_nettype none

package jetc_pkg;

  // Width of a configuration register write (widest register: c_real / c_imag)
  localparam int unsigned CfgDataW = 31;
  // Register index width; index 3 is outside the list and ignored
  localparam int unsigned CfgIdxW  = 2;
  // Iteration count width
  localparam int unsigned CountW   = 8;
  // Width of the z registers; holds any value one step can produce
  localparam int unsigned ZW       = 34;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegCReal   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCImag   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMaxIter = 2'd2;

  // Reset value of the iteration limit
  localparam logic [CountW-1:0] MaxIterReset = 8'd80;

  // Input item: starting point z0
  typedef struct packed {
    logic signed [31:0] start_real;
    logic signed [31:0] start_imag;
  } jetc_in_t;

  // Result item
  typedef struct packed {
    logic [CountW-1:0] iter_count;
    logic              escaped;
  } jetc_out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // take z0 from the input, clear the count
    logic mul_en;   // register the three products
    logic upd_en;   // form the new z, bump the count
    logic out_load; // capture the result into the output register
  } jetc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cont;     // z inside the box and count below the limit
  } jetc_stat_t;

endpackage : jetc_pkg

`default_nettype wire

// ===== rtl/core/julia_escape_time_counter_core.sv =====
// Julia escape-time counter: one starting point z0 in Q(32-FRAC_BITS).FRAC_BITS goes in,
// z is replaced by z*z - c until it leaves the open square -2..2 on either axis or the
// count reaches the iteration limit, and the count plus an escaped flag come out. Each
// iteration has two steps: the one shared squaring unit registers its three products,
// then the update subtracts, floors and subtracts c. One item is worked at a time; the
// next is taken as soon as the result sits in the output register, even while stalled.
// Depends on jetc_pkg, jetc_ctrl, jetc_dp.
`default_nettype none

module julia_escape_time_counter_core #(
  parameter int unsigned FRAC_BITS = 26
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  jetc_pkg::jetc_in_t                   in_data,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output jetc_pkg::jetc_out_t                  out_data,
  input  wire                                  cfg_we,
  input  wire logic [jetc_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [jetc_pkg::CfgDataW-1:0]   cfg_wdata
);
  import jetc_pkg::*;

  logic signed [CfgDataW-1:0] c_real_r, c_imag_r;
  logic [CountW-1:0]          iter_lim_r;
  jetc_cmd_t                  cmd;
  jetc_stat_t                 stat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_real_r   <= '0;
      c_imag_r   <= '0;
      iter_lim_r <= MaxIterReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegCReal:   c_real_r   <= cfg_wdata;
        RegCImag:   c_imag_r   <= cfg_wdata;
        RegMaxIter: iter_lim_r <= cfg_wdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  jetc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  jetc_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_data),
    .c_real   (c_real_r),
    .c_imag   (c_imag_r),
    .iter_lim (iter_lim_r),
    .out_data (out_data)
  );

endmodule : julia_escape_time_counter_core

`default_nettype wire

// ===== rtl/core/jetc_dp.sv =====
// Datapath of the Julia escape-time counter: z registers, complex squaring unit,
// box test, iteration count and output register. Depends on jetc_pkg.
`default_nettype none

module jetc_dp #(
  parameter int unsigned FRAC_BITS = 26
) (
  input  wire                             clk,
  input  jetc_pkg::jetc_cmd_t             cmd,
  output jetc_pkg::jetc_stat_t            stat,
  input  jetc_pkg::jetc_in_t              in_data,
  input  wire logic signed [jetc_pkg::CfgDataW-1:0] c_real,
  input  wire logic signed [jetc_pkg::CfgDataW-1:0] c_imag,
  input  wire logic [jetc_pkg::CountW-1:0] iter_lim,
  output jetc_pkg::jetc_out_t             out_data
);
  import jetc_pkg::*;

  // Multiplier operand width: z inside the box fits FRAC_BITS+2 bits signed
  localparam int unsigned MW = FRAC_BITS + 2;
  // Product / sum width, one bit of headroom
  localparam int unsigned PW = 2 * MW + 1;
  // Width after the fraction shift
  localparam int unsigned SW = PW - FRAC_BITS;

  localparam logic signed [ZW-1:0] Two    = ZW'(64'sd2 <<< FRAC_BITS);
  localparam logic signed [ZW-1:0] NegTwo = -Two;

  logic signed [ZW-1:0]     re_r, im_r;
  logic signed [ZW-1:0]     re_nxt, im_nxt;
  logic signed [PW-1:0]     rr_r, ii_r, ri_r;
  logic [CountW-1:0]        count_r;
  jetc_out_t                out_r;

  logic signed [MW-1:0]     re_op, im_op;
  logic signed [PW-1:0]     diff, dbl;
  logic signed [SW-1:0]     diff_sh, dbl_sh;
  logic                     in_box, below;

  // Box test (strict) and limit test
  assign in_box = (re_r > NegTwo) && (re_r < Two) && (im_r > NegTwo) && (im_r < Two);
  assign below  = (count_r < iter_lim);
  assign stat.cont = in_box && below;

  // Operands are only used while z is inside the box, so the top bits are redundant
  assign re_op = re_r[MW-1:0];
  assign im_op = im_r[MW-1:0];

  // Second half of a step: combine, floor by the fraction bits, subtract c
  always_comb begin
    diff    = rr_r - ii_r;
    dbl     = ri_r <<< 1;
    diff_sh = SW'(diff >>> FRAC_BITS);
    dbl_sh  = SW'(dbl >>> FRAC_BITS);
    re_nxt  = ZW'(diff_sh) - ZW'(c_real);
    im_nxt  = ZW'(dbl_sh) - ZW'(c_imag);
  end

  // z, products and count
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      re_r    <= ZW'(in_data.start_real);
      im_r    <= ZW'(in_data.start_imag);
      count_r <= '0;
    end else if (cmd.upd_en) begin
      re_r    <= re_nxt;
      im_r    <= im_nxt;
      count_r <= count_r + CountW'(1);
    end
    if (cmd.mul_en) begin
      rr_r <= PW'(re_op * re_op);
      ii_r <= PW'(im_op * im_op);
      ri_r <= PW'(re_op * im_op);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.iter_count <= count_r;
      out_r.escaped    <= !in_box && below;
    end
  end

  assign out_data = out_r;

endmodule : jetc_dp

`default_nettype wire

// ===== rtl/core/jetc_ctrl.sv =====
// Controller of the Julia escape-time counter: sequences load, square and update
// steps and owns both handshakes. Depends on jetc_pkg.
`default_nettype none

module jetc_ctrl (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire                    out_stall,
  input  jetc_pkg::jetc_stat_t   stat,
  output jetc_pkg::jetc_cmd_t    cmd
);
  import jetc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQR,
    ST_UPD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SQR;
        end
      end
      ST_SQR: begin
        priority if (stat.cont) begin
          cmd.mul_en = 1'b1;
          state_nxt  = ST_UPD;
        end else if (!out_valid_r || !out_stall) begin
          // result goes out once the output register is free
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          // output register still held; wait here
          state_nxt = ST_SQR;
        end
      end
      ST_UPD: begin
        cmd.upd_en = 1'b1;
        state_nxt  = ST_SQR;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output valid flag
  always_comb begin
    priority if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (!out_stall)       out_valid_nxt = 1'b0;
    else                       out_valid_nxt = out_valid_r;
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule : jetc_ctrl

`default_nettype wire

// ===== test/jetc_escape_checker.sv =====
// Checker for the Julia escape-time counter: follows the register port, predicts each
// result from the accepted starting point and compares it with what the block returns.
// Depends on jetc_pkg.
`timescale 1ns / 100ps

module jetc_escape_checker #(
  parameter int unsigned FRAC_BITS = 26
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  input  wire                                  in_stall,
  input  jetc_pkg::jetc_in_t                   in_data,
  input  wire                                  out_valid,
  input  wire                                  out_stall,
  input  jetc_pkg::jetc_out_t                  out_data,
  input  wire                                  cfg_we,
  input  wire logic [jetc_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [jetc_pkg::CfgDataW-1:0]   cfg_wdata,
  output int                                   errors,
  output int                                   pending,
  output int                                   checked
);
  import jetc_pkg::*;

  // starting point kept beside its expected result for the mismatch report
  typedef struct packed {
    jetc_in_t  pt;
    jetc_out_t res;
  } escape_rec_t;

  escape_rec_t         expected_results[$];
  longint              c_re;
  longint              c_im;
  logic [CountW-1:0]   iter_limit;

  // strict box test, both axes
  function automatic bit inside_square(input longint re, input longint im);
    longint two;
    two = longint'(2) <<< FRAC_BITS;
    return (re > -two) && (re < two) && (im > -two) && (im < two);
  endfunction

  // z <- z*z - c until z leaves the box or the limit is hit; products are exact,
  // one arithmetic shift (floor) per component
  function automatic jetc_out_t escape_count(input jetc_in_t pt);
    longint      re;
    longint      im;
    longint      rr;
    longint      ii;
    longint      ri;
    longint      nre;
    int unsigned n;
    bit          in_sq;
    jetc_out_t   r;
    re = pt.start_real;
    im = pt.start_imag;
    n = 0;
    in_sq = inside_square(re, im);
    while (in_sq && n < iter_limit) begin
      rr = re * re;
      ii = im * im;
      ri = re * im;
      nre = ((rr - ii) >>> FRAC_BITS) - c_re;
      im = ((ri * 2) >>> FRAC_BITS) - c_im;
      re = nre;
      n++;
      in_sq = inside_square(re, im);
    end
    r.iter_count = n[CountW-1:0];
    r.escaped = !in_sq && (n < iter_limit);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    escape_rec_t want;
    jetc_out_t   got;
    if (!rst_n) begin
      c_re = 0;
      c_im = 0;
      iter_limit = MaxIterReset;
      expected_results.delete();
      errors = 0;
      checked = 0;
    end else begin
      // register shadow; index 3 is ignored by the block
      if (cfg_we) begin
        case (cfg_index)
          RegCReal: begin
            c_re = longint'($signed(cfg_wdata));
          end
          RegCImag: begin
            c_im = longint'($signed(cfg_wdata));
          end
          RegMaxIter: begin
            iter_limit = cfg_wdata[CountW-1:0];
          end
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) begin
        want.pt = in_data;
        want.res = escape_count(in_data);
        expected_results.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        checked++;
        if (expected_results.size() == 0) begin
          $display("%0t: result with no point outstanding: count %0d escaped %0b",
                   $time, got.iter_count, got.escaped);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.iter_count !== want.res.iter_count) begin
            $display("%0t: iter_count for z0=(%0d,%0d): expected %0d, got %0d", $time,
                     want.pt.start_real, want.pt.start_imag, want.res.iter_count,
                     got.iter_count);
            errors++;
          end
          if (got.escaped !== want.res.escaped) begin
            $display("%0t: escaped for z0=(%0d,%0d): expected %0b, got %0b", $time,
                     want.pt.start_real, want.pt.start_imag, want.res.escaped,
                     got.escaped);
            errors++;
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule : jetc_escape_checker

// ===== test/testbench.sv =====
// Top of the escape-time counter testbench: clock, reset, register settings and
// starting points, with random gaps and stalls; verdict from jetc_escape_checker.
// Depends on jetc_pkg, julia_escape_time_counter_core, jetc_escape_checker.
`timescale 1ns / 100ps

module testbench;
  import jetc_pkg::*;

  localparam int unsigned FracBits = 26;
  localparam int          Unit     = 1 << FracBits;      // 1.0
  localparam int          Two      = 2 << FracBits;      // 2.0, the box edge
  localparam logic [CfgIdxW-1:0] RegNone = 2'd3;         // past the register list
  localparam logic [CfgDataW-1:0] CMin = 31'h4000_0000;  // -16.0
  localparam logic [CfgDataW-1:0] CMax = 31'h3FFF_FFFF;  // just under +16.0

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  jetc_in_t            in_data;
  logic                out_valid;
  logic                out_stall;
  jetc_out_t           out_data;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  int  errors;
  int  pending;
  int  checked;
  int  points_sent;
  int  settings_used;
  int  steady_left;
  bit  rx_hold;

  julia_escape_time_counter_core #(
    .FRAC_BITS (FracBits)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  jetc_escape_checker #(
    .FRAC_BITS (FracBits)
  ) i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // run limit, well above the slowest legal run
  initial begin
    #50_000_000;
    $display("timeout: block stopped answering");
    $display("testbench: done, errors");
    $finish;
  end

  // result side: short stalls, free stretches, one long hold-off on request
  initial begin : receiver
    int unsigned r;
    int unsigned len;
    out_stall = 1'b0;
    forever begin
      if (rx_hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        rx_hold = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        @(negedge clk);
        if (r < 40) begin
          out_stall <= 1'b0;
          len = $urandom_range(1, 8);
        end else if (r < 75) begin
          out_stall <= 1'b1;
          len = $urandom_range(1, 3);
        end else if (r < 80) begin
          out_stall <= 1'b1;
          len = $urandom_range(5, 40);
        end else begin
          out_stall <= 1'b0;
          len = $urandom_range(20, 120);
        end
        repeat (len - 1) @(negedge clk);
      end
    end
  end

  // sender gap: mostly none, sometimes short, rarely long; stretches without gaps
  function automatic int tx_gap();
    int unsigned r;
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      steady_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // one coordinate: mostly inside the box, some near the origin, some on the edge
  function automatic int pick_coord();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 58) return int'($urandom_range(0, 2 * Two - 2)) - Two + 1;
    if (r < 72) return int'($urandom_range(0, 2 * Unit)) - Unit;
    if (r < 84) return ($urandom_range(0, 1) ? Two : -Two) + int'($urandom_range(0, 6)) - 3;
    return int'($urandom());
  endfunction

  // constant c: mostly within 1.0 where orbits stay bounded, sometimes anywhere
  function automatic logic [CfgDataW-1:0] pick_c();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return CfgDataW'(int'($urandom_range(0, 2 * Unit)) - Unit);
    if (r < 85) return CfgDataW'(int'($urandom_range(0, 2 * Two)) - Two);
    return CfgDataW'($urandom());
  endfunction

  task automatic offer_point(input int re, input int im);
    int gap;
    gap = tx_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data.start_real <= re;
    in_data.start_imag <= im;
    do @(posedge clk); while (in_stall);
    points_sent++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // new setting, block idle; junk above the limit's 8 bits must be dropped
  task automatic apply_setting(input logic [CfgDataW-1:0] c_r, input logic [CfgDataW-1:0] c_i,
                               input logic [CountW-1:0] lim);
    settle();
    write_reg(RegCReal, c_r);
    write_reg(RegCImag, c_i);
    write_reg(RegMaxIter, {23'($urandom()), lim});
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic random_points(input int n);
    int k;
    for (k = 0; k < n; k++) offer_point(pick_coord(), pick_coord());
  endtask

  initial begin : stimulus
    int k;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    rx_hold = 1'b0;
    steady_left = 0;
    points_sent = 0;
    settings_used = 1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset setting: c = 0, limit 80; field extremes and both box edges
    offer_point(0, 0);
    offer_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    offer_point(32'sh8000_0000, 32'sh8000_0000);
    offer_point(Two, 0);
    offer_point(-Two, 0);
    offer_point(0, Two);
    offer_point(0, -Two);
    offer_point(Two - 1, 0);
    offer_point(-Two + 1, 0);
    offer_point(0, Two - 1);
    offer_point(0, -Two + 1);
    offer_point(Unit, 0);                   // fixed point of z*z, runs to the limit
    offer_point(Unit + Unit / 2, 0);        // 1.5 squares past the edge
    offer_point(Two - 1, Two - 1);
    offer_point(-1, -1);
    random_points(50);
    rx_hold = 1'b1;                         // result side holds, block backs up
    random_points(150);

    // limit 255, random constant from pick_c
    apply_setting(pick_c(), pick_c(), 8'd255);
    random_points(70);
    settle();                               // sender waits for the pipe to empty
    random_points(80);

    // limit 1: escape and limit on the same step gives escaped = 0
    apply_setting('0, '0, 8'd1);
    offer_point(Unit + Unit / 2, 0);
    offer_point(Unit / 2, Unit / 2);
    random_points(200);

    // limit 0: nothing iterates; an out-of-list write must change nothing
    apply_setting(pick_c(), pick_c(), 8'd0);
    write_reg(RegNone, CfgDataW'($urandom()));
    @(negedge clk);
    cfg_we <= 1'b0;
    offer_point(0, 0);
    offer_point(3 * Unit, 0);
    random_points(150);

    // c at both extremes of its range
    apply_setting(CMin, CMax, 8'd50);
    random_points(100);
    apply_setting(CMax, CMin, 8'd200);
    random_points(100);

    // random settings
    for (k = 0; k < 4; k++) begin
      apply_setting(pick_c(), pick_c(), CountW'($urandom_range(1, 255)));
      random_points(140);
    end

    settle();
    repeat (600) @(posedge clk);
    $display("covered %0d starting points over %0d register settings (limits 0, 1, 255,",
             points_sent, settings_used);
    $display("c at both ends of its range, box edges); %0d results compared", checked);
    if (errors == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule : testbench
